// File: hw/rtl/skte_pkg.sv
// package: shared types, request and status codes, controller states for the sorted key table
`timescale 1ns / 1ps
package skte_pkg;

    localparam int KEY_BITS = 32;
    localparam int HND_PORT_BITS = 32;
    localparam int POS_BITS = 8;
    localparam int CNT_PORT_BITS = 9;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_FIND   = 3'd2,
        REQ_NEXT   = 3'd3,
        REQ_CLEAR  = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REPLACED = 2'd1,
        ST_MISSING  = 2'd2,
        ST_FULL     = 2'd3
    } status_code_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic [KEY_BITS-1:0]      line_key;
        logic [HND_PORT_BITS-1:0] text_handle;
    } req_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [POS_BITS-1:0]      position;
        logic [KEY_BITS-1:0]      entry_key;
        logic [HND_PORT_BITS-1:0] entry_handle;
        logic [CNT_PORT_BITS-1:0] entries_held;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WAIT,
        S_SHIFT_WR,
        S_FIND_RD,
        S_FIND_WAIT,
        S_RESP
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic srch_init;
        logic srch_rd;
        logic srch_step;
        logic decide;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic find_rd;
        logic find_cap;
        logic resp_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic srch_done;
        logic need_shift;
        logic shift_done;
        logic is_find;
    } dp_sts_t;

endpackage

// File: hw/rtl/sorted_key_table_engine_top.sv
// top level: sorted key table engine (binary search insert, delete, find, next, clear)
//
// requests arrive on req (req_valid/req_stall), one transaction per request,
// and each gives exactly one result transaction on rsp (rsp_valid/rsp_stall).
// the user must write capacity_limit (cfg_we/cfg_data) only while idle; the block does not enforce it.
// one request is worked at a time: req_stall is high from acceptance until
// its result is loaded into the output register.
// sequence: a binary search over the held entries, each probe a read,
// a wait and a compare, then for insert or delete a shift of the moved
// entries one at a time (read, then write) through the single memory read
// port; finds add a read of the found entry.
// reset empties the table (entry count zero), sets the limit to 256 and
// drops any pending result. when the receiver stalls, the result holds in
// the output register; the next request is still taken but its result waits.
`timescale 1ns / 1ps
module sorted_key_table_engine_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  skte_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output skte_pkg::rsp_item_t rsp,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_data
);
    import skte_pkg::*;

    logic [8:0] limit_reg;
    dp_cmd_t    cmd;
    dp_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    skte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    skte_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_in         (req),
        .capacity_limit (limit_reg),
        .rsp_out        (rsp)
    );

endmodule

// File: hw/rtl/skte_datapath.sv
// datapath: entry memories, search bounds, shift pointer and result register
`timescale 1ns / 1ps
module skte_datapath #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skte_pkg::dp_cmd_t   cmd,
    output skte_pkg::dp_sts_t   sts,
    input  skte_pkg::req_item_t req_in,
    input  logic [8:0]          capacity_limit,
    output skte_pkg::rsp_item_t rsp_out
);
    import skte_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    logic [KEY_BITS-1:0]    key_mem [TABLE_DEPTH];
    logic [HANDLE_BITS-1:0] hnd_mem [TABLE_DEPTH];

    logic [2:0]             req_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          lo_reg, lo_next, hi_reg, hi_next;
    logic                   hit_reg, hit_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [1:0]             status_reg, status_next;
    logic                   ins_reg, ins_next;
    logic [KEY_BITS-1:0]    rd_key_reg;
    logic [HANDLE_BITS-1:0] rd_hnd_reg;
    logic [KEY_BITS-1:0]    okey_reg;
    logic [HANDLE_BITS-1:0] ohnd_reg;
    rsp_item_t              rsp_reg;

    logic [CW-1:0] mid;
    logic [LW-1:0] limit_ext, cnt_ext;
    logic          lim_full;
    logic [CW-1:0] rd_addr;
    logic          mem_we;
    logic [CW-1:0] wr_addr;
    logic [KEY_BITS-1:0]    wr_key;
    logic [HANDLE_BITS-1:0] wr_hnd;
    logic          wr_key_en;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign limit_ext = LW'(capacity_limit);
    assign cnt_ext = LW'(count_reg);
    assign lim_full = (LW'(TABLE_DEPTH) < limit_ext) ? (cnt_ext >= LW'(TABLE_DEPTH))
                                                    : (cnt_ext >= limit_ext);

    always_comb
    begin
        rd_addr = mid;
        if (cmd.shift_rd)
        begin
            rd_addr = ins_reg ? (ptr_reg - CW'(1)) : (ptr_reg + CW'(1));
        end
        else if (cmd.find_rd)
        begin
            rd_addr = lo_reg;
        end
    end

    // decide writes replaced handle; shift writes moved entry; result load writes final slot
    always_comb
    begin
        mem_we = 1'b0;
        wr_addr = ptr_reg;
        wr_key = rd_key_reg;
        wr_hnd = rd_hnd_reg;
        wr_key_en = 1'b1;
        if (cmd.shift_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.decide && req_reg == REQ_INSERT)
        begin
            if (hit_reg)
            begin
                mem_we = 1'b1;
                wr_addr = lo_reg;
                wr_hnd = hnd_reg;
                wr_key_en = 1'b0;
            end
        end
        else if (cmd.resp_load && ins_reg && status_reg == ST_DONE)
        begin
            mem_we = 1'b1;
            wr_addr = lo_reg;
            wr_key = key_reg;
            wr_hnd = hnd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (wr_key_en)
            begin
                key_mem[wr_addr[AW-1:0]] <= wr_key;
            end
            hnd_mem[wr_addr[AW-1:0]] <= wr_hnd;
        end
        rd_key_reg <= key_mem[rd_addr[AW-1:0]];
        rd_hnd_reg <= hnd_mem[rd_addr[AW-1:0]];
    end

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        hit_next = hit_reg;
        ptr_next = ptr_reg;
        status_next = status_reg;
        ins_next = ins_reg;
        count_next = count_reg;
        if (cmd.srch_init)
        begin
            lo_next = '0;
            hi_next = count_reg;
            hit_next = 1'b0;
        end
        if (cmd.srch_step)
        begin
            if (rd_key_reg == key_reg)
            begin
                hit_next = 1'b1;
                lo_next = mid;
                hi_next = mid;
            end
            else if (rd_key_reg < key_reg)
            begin
                lo_next = mid + CW'(1);
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.decide)
        begin
            ins_next = 1'b0;
            status_next = ST_DONE;
            case (req_reg)
                REQ_INSERT:
                begin
                    if (hit_reg)
                    begin
                        status_next = ST_REPLACED;
                    end
                    else if (lim_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ins_next = 1'b1;
                    end
                end
                REQ_DELETE:
                begin
                    if (!hit_reg)
                    begin
                        status_next = ST_MISSING;
                    end
                end
                REQ_FIND:
                begin
                    if (!hit_reg)
                    begin
                        status_next = ST_MISSING;
                    end
                end
                REQ_NEXT:
                begin
                    if (lo_reg >= count_reg)
                    begin
                        status_next = ST_MISSING;
                    end
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_MISSING;
                end
            endcase
        end
        if (cmd.shift_init)
        begin
            ptr_next = ins_reg ? count_reg : lo_reg;
        end
        if (cmd.shift_wr)
        begin
            ptr_next = ins_reg ? (ptr_reg - CW'(1)) : (ptr_reg + CW'(1));
        end
        if (cmd.resp_load && status_reg == ST_DONE)
        begin
            if (ins_reg)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (req_reg == REQ_DELETE)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        hit_reg <= hit_next;
        ptr_reg <= ptr_next;
        status_reg <= status_next;
        ins_reg <= ins_next;
        if (cmd.load_req)
        begin
            req_reg <= req_in.req_type;
            key_reg <= req_in.line_key;
            hnd_reg <= req_in.text_handle[HANDLE_BITS-1:0];
        end
        if (cmd.find_cap)
        begin
            okey_reg <= rd_key_reg;
            ohnd_reg <= rd_hnd_reg;
        end
        if (cmd.resp_load)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.position <= (status_reg == ST_DONE || status_reg == ST_REPLACED)
                                && req_reg != REQ_CLEAR ? POS_BITS'(lo_reg) : '0;
            rsp_reg.entry_key <= (status_reg == ST_DONE && (req_reg == REQ_FIND
                                 || req_reg == REQ_NEXT)) ? okey_reg : '0;
            rsp_reg.entry_handle <= (status_reg == ST_DONE && (req_reg == REQ_FIND
                                    || req_reg == REQ_NEXT))
                                    ? HND_PORT_BITS'(ohnd_reg) : '0;
            rsp_reg.entries_held <= CNT_PORT_BITS'(count_next);
        end
    end

    assign sts.srch_done = (lo_reg >= hi_reg);
    assign sts.need_shift = ins_reg ? (count_reg > lo_reg)
                          : (req_reg == REQ_DELETE && status_reg == ST_DONE
                             && (lo_reg + CW'(1) < count_reg));
    assign sts.shift_done = ins_reg ? (ptr_reg <= lo_reg + CW'(1))
                                    : (ptr_reg + CW'(2) >= count_reg);
    assign sts.is_find = (status_reg == ST_DONE)
                         && (req_reg == REQ_FIND || req_reg == REQ_NEXT);
    assign rsp_out = rsp_reg;

endmodule

// File: hw/rtl/skte_ctrl.sv
// controller: sequences search, shift, find read and result hand-off
`timescale 1ns / 1ps
module skte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  skte_pkg::dp_sts_t sts,
    output skte_pkg::dp_cmd_t cmd
);
    import skte_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (req_valid) state_next = S_SRCH_RD;
            S_SRCH_RD:    state_next = sts.srch_done ? S_DECIDE : S_SRCH_WAIT;
            S_SRCH_WAIT:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:   state_next = S_SRCH_RD;
            S_DECIDE:     state_next = S_SHIFT_RD;
            S_SHIFT_RD:
            begin
                if (sts.is_find)
                begin
                    state_next = S_FIND_RD;
                end
                else if (sts.need_shift)
                begin
                    state_next = S_SHIFT_WAIT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_SHIFT_WAIT: state_next = S_SHIFT_WR;
            S_SHIFT_WR:   state_next = sts.shift_done ? S_RESP : S_SHIFT_WAIT;
            S_FIND_RD:    state_next = S_FIND_WAIT;
            S_FIND_WAIT:  state_next = S_RESP;
            S_RESP:       if (!rsp_valid_reg || !rsp_stall) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_req = req_valid;
                cmd.srch_init = req_valid;
            end
            S_SRCH_RD:    cmd.srch_rd = 1'b1;
            S_SRCH_CMP:   cmd.srch_step = 1'b1;
            S_DECIDE:     cmd.decide = 1'b1;
            S_SHIFT_RD:
            begin
                cmd.shift_init = 1'b1;
            end
            S_SHIFT_WAIT: cmd.shift_rd = 1'b1;
            S_SHIFT_WR:   cmd.shift_wr = 1'b1;
            S_FIND_RD:    cmd.find_rd = 1'b1;
            S_FIND_WAIT:  cmd.find_cap = 1'b1;
            S_RESP:       cmd.resp_load = !rsp_valid_reg || !rsp_stall;
            default:      cmd = '0;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.resp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |-> state_reg == S_IDLE)
        else $error("request loaded outside idle");
    a_resp_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |=> rsp_valid_reg)
        else $error("result not presented");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !cmd.resp_load)
        else $error("pending result overwritten");

endmodule
